// ===== rtl/usb_endpoint_descriptor_extractor_defines.svh =====
// Assertion helpers shared by the RTL. Every property is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef USB_ENDPOINT_DESCRIPTOR_EXTRACTOR_DEFINES_SVH
`define USB_ENDPOINT_DESCRIPTOR_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UEDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UEDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uede_pkg.sv =====
package uede_pkg;

  localparam int unsigned CFG_W = 5;

  localparam logic [CFG_W-1:0] ENDPOINT_LIMIT    = 5'd31;
  localparam logic [CFG_W-1:0] MAX_EP_RESET      = 5'd31;

  localparam logic [15:0] HEADER_BYTES  = 16'd9;
  localparam logic [15:0] TL_LO_POS     = 16'd2;
  localparam logic [15:0] TL_HI_POS     = 16'd3;
  localparam logic [7:0]  TYPE_ENDPOINT = 8'd5;
  localparam logic [7:0]  MIN_SUB_LEN   = 8'd2;
  localparam logic [7:0]  MIN_EP_LEN    = 8'd7;

  // Byte offsets inside an endpoint descriptor.
  localparam logic [7:0] EP_OFS_TYPE    = 8'd1;
  localparam logic [7:0] EP_OFS_ADDR    = 8'd2;
  localparam logic [7:0] EP_OFS_ATTR    = 8'd3;
  localparam logic [7:0] EP_OFS_MPS_LO  = 8'd4;
  localparam logic [7:0] EP_OFS_MPS_HI  = 8'd5;
  localparam logic [7:0] EP_OFS_INTERVAL = 8'd6;

  typedef enum logic [1:0] {
    REASON_END     = 2'd0,
    REASON_LIMIT   = 2'd1,
    REASON_INVALID = 2'd2
  } stop_reason_t;

endpackage

// ===== rtl/uede_if.sv =====
interface uede_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_blob;

  modport source (output valid, output data_byte, output start_of_blob, input ready);
  modport sink   (input valid, input data_byte, input start_of_blob, output ready);
endinterface

interface uede_out_if;
  logic        valid;
  logic        ready;
  logic        endpoint_valid;
  logic [3:0]  endpoint_number;
  logic        endpoint_in;
  logic [1:0]  transfer_type;
  logic [10:0] packet_size;
  logic [7:0]  poll_interval;
  logic        parse_done;
  logic [4:0]  endpoint_count;
  logic [1:0]  stop_reason;

  modport source (
    output valid, output endpoint_valid, output endpoint_number, output endpoint_in,
    output transfer_type, output packet_size, output poll_interval, output parse_done,
    output endpoint_count, output stop_reason, input ready
  );
  modport sink (
    input valid, input endpoint_valid, input endpoint_number, input endpoint_in,
    input transfer_type, input packet_size, input poll_interval, input parse_done,
    input endpoint_count, input stop_reason, output ready
  );
endinterface

// ===== rtl/usb_endpoint_descriptor_extractor.sv =====
// A result appears on out_ch in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the single output register sets this, and a new
// byte is taken whenever that register is empty or is being emptied in the same cycle.
// Reset (rst_n low, synchronous): walk state cleared, parser idle until a start byte,
// max_endpoints back to 31, no result pending.
`include "usb_endpoint_descriptor_extractor_defines.svh"

module usb_endpoint_descriptor_extractor (
  input  logic                      clk,
  input  logic                      rst_n,
  uede_in_if.sink                   in_ch,
  uede_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [uede_pkg::CFG_W-1:0] cfg_wdata
);
  import uede_pkg::*;

  logic [CFG_W-1:0] max_ep_r;

  logic [15:0] blob_offset_r, blob_offset_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  sub_offset_r, sub_offset_nxt;
  logic [7:0]  sub_length_r, sub_length_nxt;
  logic [7:0]  sub_type_r, sub_type_nxt;
  logic [7:0]  address_r, address_nxt;
  logic [7:0]  attribute_r, attribute_nxt;
  logic [15:0] mps_r, mps_nxt;
  logic [7:0]  interval_r, interval_nxt;
  logic [4:0]  found_r, found_nxt;
  logic        stopped_r, stopped_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        ep_valid_r;
  logic [3:0]  ep_num_r;
  logic        ep_in_r;
  logic [1:0]  xfer_r;
  logic [10:0] max_pkt_r;
  logic [7:0]  poll_r;
  logic        done_r;
  logic [4:0]  count_r;
  stop_reason_t reason_r;

  logic         accept;
  logic         active;
  logic         boundary;
  logic         done;
  logic         emit_ep;
  stop_reason_t reason;
  logic [15:0]  pos;
  logic [CFG_W-1:0] limit;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign limit       = (max_ep_r < ENDPOINT_LIMIT) ? max_ep_r : ENDPOINT_LIMIT;

  always_comb begin
    blob_offset_nxt  = blob_offset_r;
    total_length_nxt = total_length_r;
    sub_offset_nxt   = sub_offset_r;
    sub_length_nxt   = sub_length_r;
    sub_type_nxt     = sub_type_r;
    address_nxt      = address_r;
    attribute_nxt    = attribute_r;
    mps_nxt          = mps_r;
    interval_nxt     = interval_r;
    found_nxt        = found_r;
    stopped_nxt      = stopped_r;
    active           = 1'b0;
    boundary         = 1'b0;
    done             = 1'b0;
    emit_ep          = 1'b0;
    reason           = REASON_END;

    if (accept) begin
      if (in_ch.start_of_blob) begin
        // A start byte restarts the walk from a clean state, even mid-descriptor.
        blob_offset_nxt  = '0;
        total_length_nxt = '0;
        sub_offset_nxt   = '0;
        sub_length_nxt   = '0;
        sub_type_nxt     = '0;
        address_nxt      = '0;
        attribute_nxt    = '0;
        mps_nxt          = '0;
        interval_nxt     = '0;
        found_nxt        = '0;
        stopped_nxt      = 1'b0;
        active           = 1'b1;
      end else begin
        active = !stopped_r;
      end
    end

    pos = blob_offset_nxt;

    if (active) begin
      if (pos < HEADER_BYTES) begin
        if (pos == TL_LO_POS) begin
          total_length_nxt[7:0] = in_ch.data_byte;
        end else if (pos == TL_HI_POS) begin
          total_length_nxt[15:8] = in_ch.data_byte;
        end else if (pos == HEADER_BYTES - 16'd1) begin
          boundary = 1'b1;
        end
      end else if (sub_offset_nxt == '0) begin
        sub_length_nxt = in_ch.data_byte;
        if (in_ch.data_byte < MIN_SUB_LEN ||
            ({1'b0, pos} + {9'd0, in_ch.data_byte}) > {1'b0, total_length_nxt}) begin
          done   = 1'b1;
          reason = REASON_INVALID;
        end else begin
          sub_offset_nxt = EP_OFS_TYPE;
        end
      end else begin
        if (sub_offset_nxt == EP_OFS_TYPE) begin
          sub_type_nxt = in_ch.data_byte;
          if (in_ch.data_byte == TYPE_ENDPOINT && sub_length_nxt < MIN_EP_LEN) begin
            done   = 1'b1;
            reason = REASON_INVALID;
          end
        end else if (sub_type_nxt == TYPE_ENDPOINT) begin
          unique case (sub_offset_nxt)
            EP_OFS_ADDR:     address_nxt   = in_ch.data_byte;
            EP_OFS_ATTR:     attribute_nxt = in_ch.data_byte;
            EP_OFS_MPS_LO:   mps_nxt[7:0]  = in_ch.data_byte;
            EP_OFS_MPS_HI:   mps_nxt[15:8] = in_ch.data_byte;
            EP_OFS_INTERVAL: interval_nxt  = in_ch.data_byte;
            default:         ;
          endcase
        end
        if (!done) begin
          if (({1'b0, sub_offset_nxt} + 9'd1) >= {1'b0, sub_length_nxt}) begin
            boundary       = 1'b1;
            sub_offset_nxt = '0;
            if (sub_type_nxt == TYPE_ENDPOINT) begin
              emit_ep   = 1'b1;
              found_nxt = found_nxt + 5'd1;
            end
          end else begin
            sub_offset_nxt = sub_offset_nxt + 8'd1;
          end
        end
      end

      // At each descriptor boundary the end of the total length wins over the limit.
      if (boundary) begin
        if (({1'b0, pos} + 17'd1) >= {1'b0, total_length_nxt}) begin
          done   = 1'b1;
          reason = REASON_END;
        end else if (found_nxt >= limit) begin
          done   = 1'b1;
          reason = REASON_LIMIT;
        end
      end

      blob_offset_nxt = pos + 16'd1;
      if (done) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && (emit_ep || done)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ep_r       <= MAX_EP_RESET;
      blob_offset_r  <= '0;
      total_length_r <= '0;
      sub_offset_r   <= '0;
      sub_length_r   <= '0;
      sub_type_r     <= '0;
      address_r      <= '0;
      attribute_r    <= '0;
      mps_r          <= '0;
      interval_r     <= '0;
      found_r        <= '0;
      stopped_r      <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_ep_r <= cfg_wdata;
      end
      blob_offset_r  <= blob_offset_nxt;
      total_length_r <= total_length_nxt;
      sub_offset_r   <= sub_offset_nxt;
      sub_length_r   <= sub_length_nxt;
      sub_type_r     <= sub_type_nxt;
      address_r      <= address_nxt;
      attribute_r    <= attribute_nxt;
      mps_r          <= mps_nxt;
      interval_r     <= interval_nxt;
      found_r        <= found_nxt;
      stopped_r      <= stopped_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload; the endpoint fields read as zero when no endpoint completed.
  always_ff @(posedge clk) begin
    if (accept && (emit_ep || done)) begin
      ep_valid_r <= emit_ep;
      ep_num_r   <= emit_ep ? address_nxt[3:0] : 4'd0;
      ep_in_r    <= emit_ep ? address_nxt[7] : 1'b0;
      xfer_r     <= emit_ep ? attribute_nxt[1:0] : 2'd0;
      max_pkt_r  <= emit_ep ? mps_nxt[10:0] : 11'd0;
      poll_r     <= emit_ep ? interval_nxt : 8'd0;
      done_r     <= done;
      count_r    <= found_nxt;
      reason_r   <= done ? reason : REASON_END;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.endpoint_valid  = ep_valid_r;
  assign out_ch.endpoint_number = ep_num_r;
  assign out_ch.endpoint_in     = ep_in_r;
  assign out_ch.transfer_type   = xfer_r;
  assign out_ch.packet_size     = max_pkt_r;
  assign out_ch.poll_interval   = poll_r;
  assign out_ch.parse_done      = done_r;
  assign out_ch.endpoint_count  = count_r;
  assign out_ch.stop_reason     = reason_r;

  `UEDE_ASSERT_SAME(a_result_has_content, out_valid_r, ep_valid_r || done_r,
    "pending result carries neither an endpoint nor a stop")
  `UEDE_ASSERT_SAME(a_reason_only_when_done, out_valid_r && !done_r, reason_r == REASON_END,
    "stop reason set on a result that does not end the walk")
  `UEDE_ASSERT_NEXT(a_stop_latches, accept && done, stopped_r,
    "walk did not stop after its final byte")
  `UEDE_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_ch.ready,
    "input stalled with an empty output register")
  `UEDE_ASSERT_NEXT(a_idle_bytes_ignored, accept && stopped_r && !in_ch.start_of_blob,
    stopped_r && $stable(blob_offset_r),
    "byte without start flag advanced a stopped walk")

endmodule
